// ===== hw/rtl/lcpf_pkg.sv =====
// Package: widths, codes and payload types of the light curve phase folder.
package lcpf_pkg;

  localparam int TIME_W     = 56;
  localparam int FREQ_W     = 40;
  localparam int MAG_W      = 32;
  localparam int PROD_W     = 56;
  localparam int PHASE_BITS = 24;
  localparam int PHASE_W    = PHASE_BITS + 2;

  localparam int CFG_W      = 56;
  localparam int CFG_IDX_W  = 2;
  localparam int MODE_W     = 2;

  // product split into partial products
  localparam int D_LO_W = 28;
  localparam int F_LO_W = 20;
  localparam int F_HI_W = FREQ_W - F_LO_W;
  localparam int PART_W = D_LO_W + F_LO_W;

  localparam logic [CFG_IDX_W-1:0] CFG_EPOCH     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FREQUENCY = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FOLD_MODE = 2'd2;

  localparam logic [MODE_W-1:0] FOLD_UPPER = 2'd0;
  localparam logic [MODE_W-1:0] FOLD_PLUS  = 2'd1;
  localparam logic [MODE_W-1:0] FOLD_NONE  = 2'd2;

  localparam logic [TIME_W-1:0] EPOCH_RST     = '0;
  localparam logic [FREQ_W-1:0] FREQUENCY_RST = FREQ_W'(64'h1_0000_0000);
  localparam logic [MODE_W-1:0] FOLD_MODE_RST = FOLD_UPPER;

  localparam logic [PHASE_BITS-1:0] PHASE_HALF = PHASE_BITS'(1) << (PHASE_BITS - 1);
  localparam logic [PHASE_W-1:0]    PHASE_ONE  = PHASE_W'(1) << PHASE_BITS;

  typedef struct packed {
    logic signed [TIME_W-1:0] obs_time;
    logic [MAG_W-1:0]         obs_magnitude;
    logic                     curve_end_in;
  } in_item_t;

  typedef struct packed {
    logic signed [PHASE_W-1:0] phase_out;
    logic [MAG_W-1:0]          magnitude_out;
    logic signed [TIME_W-1:0]  time_out;
    logic                      is_copy;
    logic                      run_last;
    logic                      curve_end_out;
  } out_item_t;

  typedef struct packed {
    logic [PART_W-1:0] p_ll;
    logic [PART_W-1:0] p_lh;
    logic [PART_W-1:0] p_hl;
    logic [PART_W-1:0] p_hh;
    in_item_t          obs;
  } part_stage_t;

  typedef struct packed {
    logic [PROD_W-1:0] frac;
    in_item_t          obs;
  } frac_stage_t;

endpackage

// ===== hw/rtl/lcpf_mult.sv =====
// Time difference and partial products of the phase multiply, two stages.
module lcpf_mult (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  lcpf_pkg::in_item_t             in_data,
  input  logic [lcpf_pkg::TIME_W-1:0]    epoch,
  input  logic [lcpf_pkg::FREQ_W-1:0]    frequency,
  output logic                           part_valid,
  input  logic                           part_take,
  output lcpf_pkg::part_stage_t          part_data
);

  logic                          diff_valid;
  logic [lcpf_pkg::PROD_W-1:0]   diff;
  lcpf_pkg::in_item_t            diff_obs;
  logic                          diff_ready;
  logic                          part_ready;

  logic [lcpf_pkg::D_LO_W-1:0]                  d_lo;
  logic [lcpf_pkg::PROD_W-lcpf_pkg::D_LO_W-1:0] d_hi;
  logic [lcpf_pkg::F_LO_W-1:0]                  f_lo;
  logic [lcpf_pkg::F_HI_W-1:0]                  f_hi;

  assign part_ready = !part_valid || part_take;
  assign diff_ready = !diff_valid || part_ready;
  assign in_stall   = !diff_ready;

  assign d_lo = diff[lcpf_pkg::D_LO_W-1:0];
  assign d_hi = diff[lcpf_pkg::PROD_W-1:lcpf_pkg::D_LO_W];
  assign f_lo = frequency[lcpf_pkg::F_LO_W-1:0];
  assign f_hi = frequency[lcpf_pkg::FREQ_W-1:lcpf_pkg::F_LO_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      diff_valid <= 1'b0;
      part_valid <= 1'b0;
    end else begin
      if (diff_ready) diff_valid <= in_valid;
      if (part_ready) part_valid <= diff_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (diff_ready && in_valid) begin
      diff     <= lcpf_pkg::PROD_W'(in_data.obs_time - $signed(epoch));
      diff_obs <= in_data;
    end
    if (part_ready && diff_valid) begin
      part_data.p_ll <= lcpf_pkg::PART_W'(d_lo) * lcpf_pkg::PART_W'(f_lo);
      part_data.p_lh <= lcpf_pkg::PART_W'(d_lo) * lcpf_pkg::PART_W'(f_hi);
      part_data.p_hl <= lcpf_pkg::PART_W'(d_hi) * lcpf_pkg::PART_W'(f_lo);
      part_data.p_hh <= lcpf_pkg::PART_W'(d_hi) * lcpf_pkg::PART_W'(f_hi);
      part_data.obs  <= diff_obs;
    end
  end

endmodule

// ===== hw/rtl/lcpf_sum.sv =====
// Sum of the partial products modulo one cycle: the floored phase fraction.
module lcpf_sum (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   part_valid,
  output logic                   part_take,
  input  lcpf_pkg::part_stage_t  part_data,
  output logic                   frac_valid,
  input  logic                   frac_take,
  output lcpf_pkg::frac_stage_t  frac_data
);

  logic                        frac_ready;
  logic [lcpf_pkg::PROD_W-1:0] frac_next;

  assign frac_ready = !frac_valid || frac_take;
  assign part_take  = part_valid && frac_ready;

  assign frac_next = lcpf_pkg::PROD_W'(part_data.p_ll)
                   + (lcpf_pkg::PROD_W'(part_data.p_lh) << lcpf_pkg::F_LO_W)
                   + (lcpf_pkg::PROD_W'(part_data.p_hl) << lcpf_pkg::D_LO_W)
                   + (lcpf_pkg::PROD_W'(part_data.p_hh) << lcpf_pkg::PART_W);

  always_ff @(posedge clk) begin
    if (rst) begin
      frac_valid <= 1'b0;
    end else if (frac_ready) begin
      frac_valid <= part_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (part_take) begin
      frac_data.frac <= frac_next;
      frac_data.obs  <= part_data.obs;
    end
  end

endmodule

// ===== hw/rtl/lcpf_emit.sv =====
// Fold decision and result register with the pending shifted copy.
module lcpf_emit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [lcpf_pkg::MODE_W-1:0]    fold_mode,
  input  logic                           frac_valid,
  output logic                           frac_take,
  input  lcpf_pkg::frac_stage_t          frac_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output lcpf_pkg::out_item_t            out_data
);

  logic                               pend;
  lcpf_pkg::out_item_t                pend_item;
  logic                               out_xfer;
  logic [lcpf_pkg::PHASE_BITS-1:0]    phase;
  logic [lcpf_pkg::PHASE_W-1:0]       phase_ext;
  logic [lcpf_pkg::PHASE_W-1:0]       copy_phase;
  logic                               copy;
  lcpf_pkg::out_item_t                orig_item;
  lcpf_pkg::out_item_t                copy_item;

  assign out_xfer  = out_valid && !out_stall;
  assign frac_take = frac_valid && !pend && (!out_valid || out_xfer);

  assign phase     = frac_data.frac[lcpf_pkg::PROD_W-1 -: lcpf_pkg::PHASE_BITS];
  assign phase_ext = {{(lcpf_pkg::PHASE_W - lcpf_pkg::PHASE_BITS){1'b0}}, phase};

  always_comb begin
    case (fold_mode)
      lcpf_pkg::FOLD_PLUS: begin
        copy       = 1'b1;
        copy_phase = phase_ext + lcpf_pkg::PHASE_ONE;
      end
      lcpf_pkg::FOLD_NONE: begin
        copy       = 1'b0;
        copy_phase = '0;
      end
      default: begin
        copy       = phase > lcpf_pkg::PHASE_HALF;
        copy_phase = phase_ext - lcpf_pkg::PHASE_ONE;
      end
    endcase
  end

  always_comb begin
    orig_item.phase_out     = $signed(phase_ext);
    orig_item.magnitude_out = frac_data.obs.obs_magnitude;
    orig_item.time_out      = frac_data.obs.obs_time;
    orig_item.is_copy       = 1'b0;
    orig_item.run_last      = !copy;
    orig_item.curve_end_out = !copy && frac_data.obs.curve_end_in;

    copy_item               = orig_item;
    copy_item.phase_out     = $signed(copy_phase);
    copy_item.is_copy       = 1'b1;
    copy_item.run_last      = 1'b1;
    copy_item.curve_end_out = frac_data.obs.curve_end_in;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      pend      <= 1'b0;
    end else if (out_xfer && pend) begin
      pend <= 1'b0;
    end else if (frac_take) begin
      out_valid <= 1'b1;
      pend      <= copy;
    end else if (out_xfer) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_xfer && pend) begin
      out_data <= pend_item;
    end else if (frac_take) begin
      out_data  <= orig_item;
      pend_item <= copy_item;
    end
  end

endmodule

// ===== hw/rtl/light_curve_phase_folder.sv =====
// Top level of the light curve phase folder: configuration and pipeline.
//
//  channel  direction  handshake               payload
//  in       input      in_valid / in_stall     lcpf_pkg::in_item_t
//  out      output     out_valid / out_stall   lcpf_pkg::out_item_t
//  cfg      input      cfg_write               cfg_index, cfg_data
//
// An item with no copy leaves one result, so such items enter one per cycle while out does
// not stall; with a copy it leaves two and holds the result register until the copy has left.
// The first result passes the difference, partial product, fraction and result registers.
// Reset clears all valid flags and loads the register reset values.
// A stall on out backs up through the difference, partial product, fraction and result registers to in_stall.
module light_curve_phase_folder (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  lcpf_pkg::in_item_t              in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output lcpf_pkg::out_item_t             out_data,
  input  logic                            cfg_write,
  input  logic [lcpf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lcpf_pkg::CFG_W-1:0]      cfg_data
);

  logic [lcpf_pkg::TIME_W-1:0] epoch;
  logic [lcpf_pkg::FREQ_W-1:0] frequency;
  logic [lcpf_pkg::MODE_W-1:0] fold_mode;

  logic                  part_valid;
  logic                  part_take;
  lcpf_pkg::part_stage_t part_data;
  logic                  frac_valid;
  logic                  frac_take;
  lcpf_pkg::frac_stage_t frac_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      epoch     <= lcpf_pkg::EPOCH_RST;
      frequency <= lcpf_pkg::FREQUENCY_RST;
      fold_mode <= lcpf_pkg::FOLD_MODE_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        lcpf_pkg::CFG_EPOCH:     epoch     <= cfg_data[lcpf_pkg::TIME_W-1:0];
        lcpf_pkg::CFG_FREQUENCY: frequency <= cfg_data[lcpf_pkg::FREQ_W-1:0];
        lcpf_pkg::CFG_FOLD_MODE: fold_mode <= cfg_data[lcpf_pkg::MODE_W-1:0];
        default: ;
      endcase
    end
  end

  lcpf_mult u_mult (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .epoch      (epoch),
    .frequency  (frequency),
    .part_valid (part_valid),
    .part_take  (part_take),
    .part_data  (part_data)
  );

  lcpf_sum u_sum (
    .clk        (clk),
    .rst        (rst),
    .part_valid (part_valid),
    .part_take  (part_take),
    .part_data  (part_data),
    .frac_valid (frac_valid),
    .frac_take  (frac_take),
    .frac_data  (frac_data)
  );

  lcpf_emit u_emit (
    .clk        (clk),
    .rst        (rst),
    .fold_mode  (fold_mode),
    .frac_valid (frac_valid),
    .frac_take  (frac_take),
    .frac_data  (frac_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

`ifndef SYNTHESIS
  a_copy_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.is_copy |-> out_data.run_last)
    else $error("copy result not marked last");

  a_end_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.curve_end_out |-> out_data.run_last)
    else $error("curve end on a result that is not last");

  a_copy_follows: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !out_data.run_last |=> out_valid && out_data.is_copy)
    else $error("original without last flag not followed by its copy");

  a_no_copy_none: assert property (@(posedge clk) disable iff (rst)
    out_valid && fold_mode == lcpf_pkg::FOLD_NONE |-> out_data.run_last)
    else $error("result without last flag in no-copy mode");
`endif

endmodule

// ===== dv/light_curve_phase_folder_tb.sv =====
// Testbench for light_curve_phase_folder: directed table and random observations.
`timescale 1ns / 1ps

module light_curve_phase_folder_tb;

  localparam logic [lcpf_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam int DIR_N        = 16;
  localparam int RAND_SETS    = 8;
  localparam int SET_ITEMS    = 100;
  localparam int HOLD_CYCLES  = 300;
  localparam int TAIL_CYCLES  = 20;
  localparam int TIMEOUT_NS   = 8_000_000;

  typedef struct packed {
    bit                           cfg;
    logic [lcpf_pkg::CFG_W-1:0]   epoch_d;
    logic [lcpf_pkg::CFG_W-1:0]   freq_d;
    logic [lcpf_pkg::CFG_W-1:0]   mode_d;
    lcpf_pkg::in_item_t           obs;
    logic [1:0]                   n_typed;
    logic [lcpf_pkg::PHASE_W-1:0] ph0;
    logic [lcpf_pkg::PHASE_W-1:0] ph1;
  } dir_row_t;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           in_valid = 1'b0;
  logic                           in_stall;
  lcpf_pkg::in_item_t             in_data = '0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  lcpf_pkg::out_item_t            out_data;
  logic                           cfg_write = 1'b0;
  logic [lcpf_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [lcpf_pkg::CFG_W-1:0]     cfg_data = '0;

  // folder settings as last written
  logic signed [lcpf_pkg::TIME_W-1:0] epoch_r;
  logic [lcpf_pkg::FREQ_W-1:0]        freq_r;
  logic [lcpf_pkg::MODE_W-1:0]        mode_r;

  lcpf_pkg::out_item_t fold_q[$];
  lcpf_pkg::out_item_t folded_want;
  int        fail_cnt = 0;
  int        send_idle_pct = 0;
  int        stall_pct = 0;
  int        hold_asked = 0;
  int        hold_given = 0;
  int        hold_left = 0;

  // directed rows: phases typed where they follow from the low time bits at 1 cycle/day
  dir_row_t dir_tab [DIR_N] = '{
    '{1'b0, '0, '0, '0, '{56'h0, 32'h0000_0000, 1'b0}, 2'd1, 26'h0000000, 26'h0},
    '{1'b0, '0, '0, '0, '{56'h80_0000, 32'hA5A5_A5A5, 1'b0}, 2'd1, 26'h0800000, 26'h0},
    '{1'b0, '0, '0, '0, '{56'h80_0001, 32'h5A5A_5A5A, 1'b1}, 2'd2, 26'h0800001, 26'h3800001},
    '{1'b0, '0, '0, '0, '{56'h7F_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 1'b1}, 2'd2,
      26'h0FFFFFF, 26'h3FFFFFF},
    '{1'b0, '0, '0, '0, '{56'h80_0000_0000_0000, 32'h0000_0000, 1'b0}, 2'd1,
      26'h0000000, 26'h0},
    '{1'b0, '0, '0, '0, '{56'hFF_FFFF_FFFF_FFFF, 32'h0000_0001, 1'b0}, 2'd2,
      26'h0FFFFFF, 26'h3FFFFFF},
    '{1'b1, 56'h0, 56'h1_0000_0000, 56'(lcpf_pkg::FOLD_PLUS),
      '{56'h0, 32'h8000_0000, 1'b1}, 2'd2, 26'h0000000, 26'h1000000},
    '{1'b0, '0, '0, '0, '{56'hFF_FFFF, 32'h1234_5678, 1'b0}, 2'd2, 26'h0FFFFFF, 26'h1FFFFFF},
    '{1'b1, 56'h0, 56'h1_0000_0000, 56'(lcpf_pkg::FOLD_NONE),
      '{56'hFF_FFFF, 32'h8765_4321, 1'b1}, 2'd1, 26'h0FFFFFF, 26'h0},
    // unused mode code, upper data bits dropped
    '{1'b1, 56'h0, 56'h1_0000_0000, 56'hFF_FFFF_FFFF_FFFF, '{56'hC0_0000, 32'h0F0F_0F0F, 1'b0},
      2'd2, 26'h0C00000, 26'h3C00000},
    '{1'b1, 56'h1, 56'h1_0000_0000, 56'(lcpf_pkg::FOLD_UPPER),
      '{56'h0, 32'hF0F0_F0F0, 1'b1}, 2'd2, 26'h0FFFFFF, 26'h3FFFFFF},
    '{1'b1, 56'h7F_FFFF_FFFF_FFFF, 56'hFF_FFFF_FFFF_FFFF, 56'(lcpf_pkg::FOLD_UPPER),
      '{56'h80_0000_0000_0000, 32'hDEAD_BEEF, 1'b0}, 2'd0, 26'h0, 26'h0},
    '{1'b0, '0, '0, '0, '{56'h7F_FFFF_FFFF_FFFF, 32'hCAFE_F00D, 1'b1}, 2'd0, 26'h0, 26'h0},
    '{1'b1, 56'h80_0000_0000_0000, 56'h0, 56'(lcpf_pkg::FOLD_PLUS),
      '{56'h123, 32'h0000_FFFF, 1'b1}, 2'd2, 26'h0000000, 26'h1000000},
    '{1'b1, 56'h0, 56'h1, 56'(lcpf_pkg::FOLD_UPPER),
      '{56'h7F_FFFF_FFFF_FFFF, 32'hFFFF_0000, 1'b0}, 2'd0, 26'h0, 26'h0},
    '{1'b0, '0, '0, '0, '{56'h0F_0F0F_0F0F_0F0F, 32'h3C3C_3C3C, 1'b1}, 2'd0, 26'h0, 26'h0}
  };

  light_curve_phase_folder DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #10 clk = ~clk;

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch %s: got %h, want %h at %0t", what, got, want, $realtime);
    fail_cnt++;
  endtask

  function automatic lcpf_pkg::out_item_t fold_point(input lcpf_pkg::in_item_t obs,
                                                     input logic [lcpf_pkg::PHASE_W-1:0] ph,
                                                     input bit dup, input bit last);
    lcpf_pkg::out_item_t pt;
    pt.phase_out     = ph;
    pt.magnitude_out = obs.obs_magnitude;
    pt.time_out      = obs.obs_time;
    pt.is_copy       = dup;
    pt.run_last      = last;
    pt.curve_end_out = last & obs.curve_end_in;
    return pt;
  endfunction

  // fraction of (time - epoch) * frequency, then the fold copy rule
  function automatic void predict_fold(input lcpf_pkg::in_item_t obs);
    logic [63:0]                     diff;
    logic [63:0]                     prod;
    logic [lcpf_pkg::PHASE_BITS-1:0] ph;
    logic [lcpf_pkg::PHASE_W-1:0]    ph_w;
    logic [lcpf_pkg::PHASE_W-1:0]    copy_ph;
    bit                              dup;
    diff    = 64'(obs.obs_time) - 64'(epoch_r);
    prod    = diff * {{(64 - lcpf_pkg::FREQ_W){1'b0}}, freq_r};
    ph      = prod[lcpf_pkg::PROD_W-1 -: lcpf_pkg::PHASE_BITS];
    ph_w    = {2'b00, ph};
    copy_ph = ph_w - lcpf_pkg::PHASE_ONE;
    case (mode_r)
      lcpf_pkg::FOLD_PLUS: begin
        dup     = 1'b1;
        copy_ph = ph_w + lcpf_pkg::PHASE_ONE;
      end
      lcpf_pkg::FOLD_NONE: dup = 1'b0;
      default:             dup = (ph > lcpf_pkg::PHASE_HALF);
    endcase
    fold_q.push_back(fold_point(obs, ph_w, 1'b0, !dup));
    if (dup)
      fold_q.push_back(fold_point(obs, copy_ph, 1'b1, 1'b1));
  endfunction

  task automatic wait_drain();
    in_valid <= 1'b0;
    while (fold_q.size() != 0)
      @(posedge clk);
  endtask

  task automatic set_fold(input logic [lcpf_pkg::CFG_W-1:0] epoch_d,
                          input logic [lcpf_pkg::CFG_W-1:0] freq_d,
                          input logic [lcpf_pkg::CFG_W-1:0] mode_d);
    cfg_write <= 1'b1;
    cfg_index <= CFG_SPARE;
    cfg_data  <= lcpf_pkg::CFG_W'({$urandom, $urandom});
    @(posedge clk);
    cfg_index <= lcpf_pkg::CFG_EPOCH;
    cfg_data  <= epoch_d;
    @(posedge clk);
    epoch_r = epoch_d;
    cfg_index <= lcpf_pkg::CFG_FREQUENCY;
    cfg_data  <= freq_d;
    @(posedge clk);
    freq_r = freq_d[lcpf_pkg::FREQ_W-1:0];
    cfg_index <= lcpf_pkg::CFG_FOLD_MODE;
    cfg_data  <= mode_d;
    @(posedge clk);
    mode_r = mode_d[lcpf_pkg::MODE_W-1:0];
    cfg_write <= 1'b0;
  endtask

  task automatic put_obs(input lcpf_pkg::in_item_t obs, input logic [1:0] n_typed,
                         input logic [lcpf_pkg::PHASE_W-1:0] ph0,
                         input logic [lcpf_pkg::PHASE_W-1:0] ph1);
    if (send_idle_pct != 0) begin
      while ($urandom_range(99) < send_idle_pct) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_data  <= obs;
    do @(posedge clk); while (in_stall);
    if (n_typed == 2'd0)
      predict_fold(obs);
    else begin
      fold_q.push_back(fold_point(obs, ph0, 1'b0, n_typed == 2'd1));
      if (n_typed == 2'd2)
        fold_q.push_back(fold_point(obs, ph1, 1'b1, 1'b1));
    end
  endtask

  function automatic lcpf_pkg::in_item_t rand_obs();
    lcpf_pkg::in_item_t obs;
    obs.obs_time      = lcpf_pkg::TIME_W'({$urandom, $urandom});
    obs.obs_magnitude = $urandom;
    obs.curve_end_in  = 1'($urandom_range(1));
    case ($urandom_range(15))
      0: obs.obs_time = {1'b0, {(lcpf_pkg::TIME_W - 1){1'b1}}};
      1: obs.obs_time = {1'b1, {(lcpf_pkg::TIME_W - 1){1'b0}}};
      2: obs.obs_time = '0;
      3: obs.obs_time = '1;
      default: ;
    endcase
    return obs;
  endfunction

  // receiver: random stall, or a long hold-off when asked
  always @(posedge clk) begin
    if (rst)
      out_stall <= 1'b0;
    else if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_asked != hold_given) begin
      out_stall  <= 1'b1;
      hold_given <= hold_asked;
      hold_left  <= HOLD_CYCLES;
    end else
      out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (fold_q.size() == 0)
        report_mismatch("result with nothing expected", 64'(out_data.phase_out), 64'h0);
      else begin
        folded_want = fold_q.pop_front();
        if (out_data.phase_out !== folded_want.phase_out)
          report_mismatch("phase_out", 64'(out_data.phase_out), 64'(folded_want.phase_out));
        if (out_data.magnitude_out !== folded_want.magnitude_out)
          report_mismatch("magnitude_out", 64'(out_data.magnitude_out),
                          64'(folded_want.magnitude_out));
        if (out_data.time_out !== folded_want.time_out)
          report_mismatch("time_out", 64'(out_data.time_out), 64'(folded_want.time_out));
        if (out_data.is_copy !== folded_want.is_copy)
          report_mismatch("is_copy", 64'(out_data.is_copy), 64'(folded_want.is_copy));
        if (out_data.run_last !== folded_want.run_last)
          report_mismatch("run_last", 64'(out_data.run_last), 64'(folded_want.run_last));
        if (out_data.curve_end_out !== folded_want.curve_end_out)
          report_mismatch("curve_end_out", 64'(out_data.curve_end_out),
                          64'(folded_want.curve_end_out));
      end
    end
  end

  initial begin
    #(TIMEOUT_NS);
    $display("status: fail");
    $finish;
  end

  initial begin
    int send_pcts [4];
    int stall_pcts [4];
    int k;
    logic [lcpf_pkg::CFG_W-1:0] epoch_d;
    logic [lcpf_pkg::CFG_W-1:0] freq_d;
    logic [lcpf_pkg::CFG_W-1:0] mode_d;
    send_pcts  = '{0, 58, 0, 19};
    stall_pcts = '{0, 0, 58, 19};
    epoch_r = lcpf_pkg::EPOCH_RST;
    freq_r  = lcpf_pkg::FREQUENCY_RST;
    mode_r  = lcpf_pkg::FOLD_MODE_RST;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int r = 0; r < DIR_N; r++) begin
      if (dir_tab[r].cfg) begin
        wait_drain();
        set_fold(dir_tab[r].epoch_d, dir_tab[r].freq_d, dir_tab[r].mode_d);
      end
      put_obs(dir_tab[r].obs, dir_tab[r].n_typed, dir_tab[r].ph0, dir_tab[r].ph1);
    end

    for (int p = 0; p < 4; p++) begin
      for (int s = 0; s < 2; s++) begin
        k = p * 2 + s;
        wait_drain();
        send_idle_pct = send_pcts[p];
        stall_pct     = stall_pcts[p];
        epoch_d = lcpf_pkg::CFG_W'({$urandom, $urandom});
        freq_d  = lcpf_pkg::CFG_W'({$urandom, $urandom});
        mode_d  = lcpf_pkg::CFG_W'({$urandom, $urandom});
        mode_d[lcpf_pkg::MODE_W-1:0] = lcpf_pkg::MODE_W'(k % 4);
        case (k)
          0: begin
            epoch_d = 56'h7F_FFFF_FFFF_FFFF;
            freq_d  = 56'hFF_FFFF_FFFF_FFFF;
          end
          1: begin
            epoch_d = 56'h80_0000_0000_0000;
            freq_d  = 56'h1;
          end
          2, 5: freq_d = 56'h1_0000_0000;
          default: ;
        endcase
        set_fold(epoch_d, freq_d, mode_d);
        for (int i = 0; i < SET_ITEMS; i++) begin
          if (k == 0 && i == 20)
            hold_asked++;
          if (k == 2 && i == 50)
            wait_drain();
          put_obs(rand_obs(), 2'd0, '0, '0);
        end
      end
    end

    wait_drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_cnt == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/lcpf_pkg.sv
hw/rtl/lcpf_mult.sv
hw/rtl/lcpf_sum.sv
hw/rtl/lcpf_emit.sv
hw/rtl/light_curve_phase_folder.sv
dv/light_curve_phase_folder_tb.sv
